/* hw/rtl/psue_pkg.sv */
// Shared types and constants for the particle swarm update engine.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package psue_pkg;

	// APB register map (register index = paddr[4:2])
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_INERTIA_START   = 3'd0;
	localparam logic [2:0] REG_INERTIA_END     = 3'd1;
	localparam logic [2:0] REG_COGNITIVE_GAIN  = 3'd2;
	localparam logic [2:0] REG_SOCIAL_GAIN     = 3'd3;
	localparam logic [2:0] REG_ITERATION_LIMIT = 3'd4;
	localparam logic [2:0] REG_SPEED_LIMIT     = 3'd5;
	localparam logic [2:0] REG_DIMS_IN_USE     = 3'd6;

	localparam logic [16:0] RST_INERTIA_START   = 17'd58982;
	localparam logic [16:0] RST_INERTIA_END     = 17'd26214;
	localparam logic [17:0] RST_COGNITIVE_GAIN  = 18'd131072;
	localparam logic [17:0] RST_SOCIAL_GAIN     = 18'd131072;
	localparam logic [15:0] RST_ITERATION_LIMIT = 16'd1200;
	localparam logic [16:0] RST_SPEED_LIMIT     = 17'd13107;
	localparam logic [7:0]  RST_DIMS_IN_USE     = 8'd30;

	// item mode codes
	localparam logic [2:0] MODE_LOAD_BOUNDS = 3'd0;
	localparam logic [2:0] MODE_INIT_ELEM   = 3'd1;
	localparam logic [2:0] MODE_INIT_FIT    = 3'd2;
	localparam logic [2:0] MODE_MOVE_ELEM   = 3'd3;
	localparam logic [2:0] MODE_MOVE_FIT    = 3'd4;
	localparam logic [2:0] MODE_CLEAR_RUN   = 3'd5;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [63:0] FIT_NONE = 64'sh7FFF_FFFF_FFFF_FFFF;

	// operation after range checks
	typedef enum logic [2:0] {
		OP_BOUNDS    = 3'd0,
		OP_INIT_ELEM = 3'd1,
		OP_INIT_FIT  = 3'd2,
		OP_MOVE      = 3'd3,
		OP_MOVE_FIT  = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_NONE      = 3'd6
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [5:0]         particle;
		logic [6:0]         dimension;
		logic signed [31:0] lower_value;
		logic signed [31:0] upper_value;
		logic [16:0]        rand_first;
		logic [16:0]        rand_second;
		logic [15:0]        iteration;
		logic signed [63:0] fitness;
	} cmd_t;

	typedef struct packed {
		logic [16:0] inertia_start;
		logic [16:0] inertia_end;
		logic [17:0] cognitive_gain;
		logic [17:0] social_gain;
		logic [15:0] iteration_limit;
		logic [16:0] speed_limit_fraction;
		logic [7:0]  dims_in_use;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (x < -40'sd2147483648) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/psue_front.sv */
// Front end: accepts items, range-checks them into operations, and
// queues them in a two-entry FIFO for the back end. Uses psue_pkg.
`default_nettype none

module psue_front import psue_pkg::*; #(
	parameter int unsigned MAX_PARTICLES = 64,
	parameter int unsigned MAX_DIMS = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output      logic               item_ready,
	input  wire logic [2:0]         mode,
	input  wire logic [5:0]         particle,
	input  wire logic [6:0]         dimension,
	input  wire logic signed [31:0] lower_value,
	input  wire logic signed [31:0] upper_value,
	input  wire logic [16:0]        rand_first,
	input  wire logic [16:0]        rand_second,
	input  wire logic [15:0]        iteration,
	input  wire logic signed [63:0] fitness,
	output      logic               q_valid,
	output      cmd_t               q_item,
	input  wire logic               q_pop
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       p_ok, d_ok, push;

	assign p_ok = 32'(particle) < MAX_PARTICLES;
	assign d_ok = 32'(dimension) < MAX_DIMS;

	always_comb begin
		cmd.particle    = particle;
		cmd.dimension   = dimension;
		cmd.lower_value = lower_value;
		cmd.upper_value = upper_value;
		cmd.rand_first  = (rand_first > ONE_Q16) ? ONE_Q16 : rand_first;
		cmd.rand_second = (rand_second > ONE_Q16) ? ONE_Q16 : rand_second;
		cmd.iteration   = iteration;
		cmd.fitness     = fitness;
		unique case (mode)
			MODE_LOAD_BOUNDS: cmd.op = d_ok ? OP_BOUNDS : OP_NONE;
			MODE_INIT_ELEM:   cmd.op = (p_ok && d_ok) ? OP_INIT_ELEM : OP_NONE;
			MODE_INIT_FIT:    cmd.op = p_ok ? OP_INIT_FIT : OP_NONE;
			MODE_MOVE_ELEM:   cmd.op = (p_ok && d_ok) ? OP_MOVE : OP_NONE;
			MODE_MOVE_FIT:    cmd.op = p_ok ? OP_MOVE_FIT : OP_NONE;
			MODE_CLEAR_RUN:   cmd.op = OP_CLEAR;
			default:          cmd.op = OP_NONE;
		endcase
	end

	assign item_ready = (cnt_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_item     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/psue_div.sv */
// Restoring divider, one quotient bit per cycle, used for the
// inertia schedule. Uses psue_pkg for the request/response structs.
`default_nettype none

module psue_div import psue_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	logic [15:0] rem_q;
	logic [32:0] quo_q;
	logic [15:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [16:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[32]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/psue_back.sv */
// Back end: sequencer with the swarm memories, the move datapath, row
// copies, global best and result register. Uses psue_pkg; drives psue_div via ports.
`default_nettype none

module psue_back import psue_pkg::*; #(
	parameter int unsigned MAX_PARTICLES = 64,
	parameter int unsigned MAX_DIMS = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               cfg_wr,
	input  wire logic               q_valid,
	input  wire cmd_t               q_item,
	output      logic               q_pop,
	output      div_req_t           div_req,
	input  wire div_rsp_t           div_rsp,
	output      logic               result_valid,
	input  wire logic               result_ready,
	output      logic signed [31:0] position,
	output      logic signed [63:0] best_fitness,
	output      logic               personal_improved,
	output      logic               global_improved
);

	localparam int unsigned DEPTH = MAX_PARTICLES * MAX_DIMS;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int unsigned PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned CW = $clog2(MAX_DIMS + 1);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_ISSUE = 11'b000_0000_0010,
		ST_DIV   = 11'b000_0000_0100,
		ST_MA    = 11'b000_0000_1000,
		ST_MB    = 11'b000_0001_0000,
		ST_MC    = 11'b000_0010_0000,
		ST_MD    = 11'b000_0100_0000,
		ST_EXEC  = 11'b000_1000_0000,
		ST_INIT2 = 11'b001_0000_0000,
		ST_COPY  = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	cmd_t   cmd_q;

	// storage
	logic signed [31:0] pos_mem [DEPTH];
	logic signed [31:0] vel_mem [DEPTH];
	logic signed [31:0] pb_mem  [DEPTH];
	logic signed [31:0] gb_mem  [MAX_DIMS];
	logic signed [31:0] lo_mem  [MAX_DIMS];
	logic signed [31:0] hi_mem  [MAX_DIMS];
	logic signed [63:0] pbs_mem [MAX_PARTICLES];
	logic signed [31:0] pos_rd_q, vel_rd_q, pb_rd_q, gb_rd_q, lo_rd_q, hi_rd_q;
	logic signed [63:0] pbs_rd_q;

	logic [31:0]        row_base;
	logic [AW-1:0]      elem_addr, pos_ra, pb_wa;
	logic [DW-1:0]      dim_addr, gb_wa;
	logic [PW-1:0]      part_addr;
	logic               pos_we, vel_we, pb_we, gb_we, bnd_we, pbs_we;
	logic signed [31:0] pos_wd, vel_wd, pb_wd;

	// inertia cache
	logic               w_valid_q;
	logic [15:0]        w_tag_q;
	logic signed [18:0] w_q;
	logic [15:0]        lim, it_sat;
	logic signed [17:0] wdiff;
	logic [16:0]        wmag;
	logic signed [18:0] wq19, w_new;
	logic               w_hit;

	// move pipeline
	logic [17:0]        k1_s1, k2_s1;
	logic signed [32:0] dp_s1, dg_s1, span_s1;
	logic signed [34:0] t0_s1;
	logic signed [34:0] t0_s2, vmax_s2;
	logic signed [35:0] t1_s2, t2_s2;
	logic signed [31:0] vel_s3;
	logic signed [34:0] ie_prod_s1;
	logic signed [50:0] wv_full, vmax_full, ie_full;
	logic signed [51:0] t1_full, t2_full;
	logic [34:0]        k1_full, k2_full;
	logic signed [39:0] v_sum, vm40, v_clamped;
	logic signed [32:0] x_sum, x_new, hi33, lo33;
	logic signed [31:0] np;

	// fitness and copies
	logic signed [63:0] gscore_q;
	logic               f_lt_pb, f_lt_gb;
	logic [CW-1:0]      n_copy, cp_j_q;
	logic [DW-1:0]      cp_idx_q;
	logic               cp_wr_q, cp_pb_q, cp_gb_q, cp_more;

	// result
	logic signed [31:0] res_pos_q;
	logic               res_pimp_q, res_gimp_q;
	logic               out_valid_q, out_load;
	logic signed [31:0] out_pos_q;
	logic signed [63:0] out_best_q;
	logic               out_pimp_q, out_gimp_q;

	// addressing
	assign row_base  = 32'(cmd_q.particle) * MAX_DIMS;
	assign elem_addr = AW'(row_base + 32'(cmd_q.dimension));
	assign dim_addr  = DW'(cmd_q.dimension);
	assign part_addr = PW'(cmd_q.particle);
	assign n_copy    = (32'(cfg.dims_in_use) > MAX_DIMS) ? CW'(MAX_DIMS)
	                                                     : CW'(cfg.dims_in_use);
	assign cp_more   = cp_j_q < n_copy;
	assign pos_ra    = (state_q == ST_COPY && cp_more) ? AW'(row_base + 32'(cp_j_q))
	                                                    : elem_addr;
	assign pb_wa     = (state_q == ST_COPY) ? AW'(row_base + 32'(cp_idx_q)) : elem_addr;
	assign gb_wa     = cp_idx_q;

	// inertia: w = start - it*(start-end)/lim, truncating toward zero
	assign lim    = (cfg.iteration_limit == 16'd0) ? 16'd1 : cfg.iteration_limit;
	assign it_sat = (cmd_q.iteration > lim) ? lim : cmd_q.iteration;
	assign wdiff  = $signed({1'b0, cfg.inertia_start}) - $signed({1'b0, cfg.inertia_end});
	assign wmag   = wdiff[17] ? 17'(-wdiff) : wdiff[16:0];
	assign wq19   = $signed({2'b00, div_rsp.quotient[16:0]});
	assign w_new  = wdiff[17] ? $signed({2'b00, cfg.inertia_start}) + wq19
	                          : $signed({2'b00, cfg.inertia_start}) - wq19;
	assign w_hit  = w_valid_q && (w_tag_q == cmd_q.iteration);

	assign div_req.start    = (state_q == ST_ISSUE) && (cmd_q.op == OP_MOVE) && !w_hit;
	assign div_req.dividend = 33'(it_sat) * 33'(wmag);
	assign div_req.divisor  = lim;

	// move arithmetic
	assign wv_full   = w_q * vel_rd_q;
	assign k1_full   = 35'(cfg.cognitive_gain) * 35'(cmd_q.rand_first);
	assign k2_full   = 35'(cfg.social_gain) * 35'(cmd_q.rand_second);
	assign t1_full   = $signed({1'b0, k1_s1}) * dp_s1;
	assign t2_full   = $signed({1'b0, k2_s1}) * dg_s1;
	assign vmax_full = $signed({1'b0, cfg.speed_limit_fraction}) * span_s1;
	assign v_sum     = 40'(t0_s2) + 40'(t1_s2) + 40'(t2_s2);
	assign vm40      = 40'(vmax_s2);

	always_comb begin
		v_clamped = v_sum;
		if (v_clamped > vm40) v_clamped = vm40;
		if (v_clamped < -vm40) v_clamped = -vm40;
	end

	assign hi33  = 33'(hi_rd_q);
	assign lo33  = 33'(lo_rd_q);
	assign x_sum = 33'(pos_rd_q) + 33'(vel_s3);

	always_comb begin
		x_new = x_sum;
		if (x_new > hi33) x_new = hi33;
		if (x_new < lo33) x_new = lo33;
	end

	// init element
	assign ie_full = $signed({1'b0, cmd_q.rand_first}) * (33'(hi_rd_q) - 33'(lo_rd_q));
	assign np      = sat32(40'(lo_rd_q) + 40'(ie_prod_s1));

	assign f_lt_pb = $signed(cmd_q.fitness) < pbs_rd_q;
	assign f_lt_gb = $signed(cmd_q.fitness) < gscore_q;

	// memory write controls
	assign pos_we = (state_q == ST_INIT2) || (state_q == ST_MD);
	assign pos_wd = (state_q == ST_MD) ? x_new[31:0] : np;
	assign vel_we = pos_we;
	assign vel_wd = (state_q == ST_MD) ? vel_s3 : 32'sd0;
	assign pb_we  = (state_q == ST_INIT2) || (state_q == ST_COPY && cp_wr_q && cp_pb_q);
	assign pb_wd  = (state_q == ST_COPY) ? pos_rd_q : np;
	assign gb_we  = (state_q == ST_COPY) && cp_wr_q && cp_gb_q;
	assign bnd_we = (state_q == ST_EXEC) && (cmd_q.op == OP_BOUNDS);
	assign pbs_we = (state_q == ST_EXEC) &&
	                ((cmd_q.op == OP_INIT_FIT) || (cmd_q.op == OP_MOVE_FIT && f_lt_pb));

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[elem_addr] <= pos_wd;
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk) begin
		if (vel_we) vel_mem[elem_addr] <= vel_wd;
		vel_rd_q <= vel_mem[elem_addr];
	end

	always_ff @(posedge clk) begin
		if (pb_we) pb_mem[pb_wa] <= pb_wd;
		pb_rd_q <= pb_mem[elem_addr];
	end

	always_ff @(posedge clk) begin
		if (gb_we) gb_mem[gb_wa] <= pos_rd_q;
		gb_rd_q <= gb_mem[dim_addr];
	end

	always_ff @(posedge clk) begin
		if (bnd_we) lo_mem[dim_addr] <= cmd_q.lower_value;
		lo_rd_q <= lo_mem[dim_addr];
	end

	always_ff @(posedge clk) begin
		if (bnd_we) hi_mem[dim_addr] <= cmd_q.upper_value;
		hi_rd_q <= hi_mem[dim_addr];
	end

	always_ff @(posedge clk) begin
		if (pbs_we) pbs_mem[part_addr] <= cmd_q.fitness;
		pbs_rd_q <= pbs_mem[part_addr];
	end

	// sequencer
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (cmd_q.op == OP_MOVE) state_d = w_hit ? ST_MA : ST_DIV;
				else state_d = ST_EXEC;
			end
			ST_DIV:   if (div_rsp.done) state_d = ST_MA;
			ST_MA:    state_d = ST_MB;
			ST_MB:    state_d = ST_MC;
			ST_MC:    state_d = ST_MD;
			ST_MD:    state_d = ST_DONE;
			ST_EXEC: begin
				unique case (cmd_q.op)
					OP_INIT_ELEM: state_d = ST_INIT2;
					OP_INIT_FIT:  state_d = f_lt_gb ? ST_COPY : ST_DONE;
					OP_MOVE_FIT:  state_d = f_lt_pb ? ST_COPY : ST_DONE;
					default:      state_d = ST_DONE;
				endcase
			end
			ST_INIT2: state_d = ST_DONE;
			ST_COPY:  if (!cp_more && !cp_wr_q) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_item;
		if (state_q == ST_MA) begin
			k1_s1   <= k1_full[33:16];
			k2_s1   <= k2_full[33:16];
			dp_s1   <= 33'(pb_rd_q) - 33'(pos_rd_q);
			dg_s1   <= 33'(gb_rd_q) - 33'(pos_rd_q);
			span_s1 <= 33'(hi_rd_q) - 33'(lo_rd_q);
			t0_s1   <= wv_full[50:16];
		end
		if (state_q == ST_MB) begin
			t0_s2   <= t0_s1;
			t1_s2   <= t1_full[51:16];
			t2_s2   <= t2_full[51:16];
			vmax_s2 <= vmax_full[50:16];
		end
		if (state_q == ST_MC) vel_s3 <= sat32(v_clamped);
		if (state_q == ST_EXEC) ie_prod_s1 <= ie_full[50:16];
		if (state_q == ST_DIV && div_rsp.done) w_q <= w_new;
		if (state_q == ST_EXEC) begin
			cp_pb_q <= (cmd_q.op == OP_MOVE_FIT);
			cp_gb_q <= ((cmd_q.op == OP_INIT_FIT) || (cmd_q.op == OP_MOVE_FIT && f_lt_pb))
			           && f_lt_gb;
		end
		if (state_q == ST_DIV && div_rsp.done) w_tag_q <= cmd_q.iteration;
		if (state_q == ST_COPY && cp_more) cp_idx_q <= DW'(cp_j_q);
		if (out_load) begin
			out_pos_q  <= res_pos_q;
			out_best_q <= gscore_q;
			out_pimp_q <= res_pimp_q;
			out_gimp_q <= res_gimp_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w_valid_q   <= 1'b0;
			gscore_q    <= FIT_NONE;
			cp_j_q      <= '0;
			cp_wr_q     <= 1'b0;
			res_pos_q   <= '0;
			res_pimp_q  <= 1'b0;
			res_gimp_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) w_valid_q <= 1'b0;
			else if (state_q == ST_DIV && div_rsp.done) w_valid_q <= 1'b1;

			if (q_pop) begin
				res_pos_q  <= '0;
				res_pimp_q <= 1'b0;
				res_gimp_q <= 1'b0;
			end
			if (state_q == ST_INIT2) res_pos_q <= np;
			if (state_q == ST_MD) res_pos_q <= x_new[31:0];

			if (state_q == ST_EXEC) begin
				cp_j_q  <= '0;
				cp_wr_q <= 1'b0;
				unique case (cmd_q.op)
					OP_INIT_FIT: begin
						res_pimp_q <= 1'b1;
						if (f_lt_gb) begin
							gscore_q   <= cmd_q.fitness;
							res_gimp_q <= 1'b1;
						end
					end
					OP_MOVE_FIT: begin
						if (f_lt_pb) begin
							res_pimp_q <= 1'b1;
							if (f_lt_gb) begin
								gscore_q   <= cmd_q.fitness;
								res_gimp_q <= 1'b1;
							end
						end
					end
					OP_CLEAR: gscore_q <= FIT_NONE;
					default: ;
				endcase
			end

			if (state_q == ST_COPY) begin
				cp_wr_q <= cp_more;
				if (cp_more) cp_j_q <= cp_j_q + CW'(1);
			end

			if (out_valid_q && result_ready) out_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
		end
	end

	assign result_valid      = out_valid_q;
	assign position          = out_pos_q;
	assign best_fitness      = out_best_q;
	assign personal_improved = out_pimp_q;
	assign global_improved   = out_gimp_q;

endmodule

`default_nettype wire

/* hw/rtl/particle_swarm_update_engine_core.sv */
// Top level of the particle swarm update engine: APB register file and the
// front/back split. Depends on psue_pkg, psue_front, psue_div, psue_back.
//
// Use: items arrive on a valid/ready channel (mode, particle, dimension,
// bounds, random draws, iteration, fitness); each item gives exactly one
// result item on a second valid/ready channel (position, best_fitness,
// personal_improved, global_improved). Gains, inertia schedule, speed limit
// and row length sit in APB registers; the user must write them only while
// the block is idle, and the block itself does not enforce this.
// A two-entry queue sits between the accepting front end and the executing
// back end, and the back end holds its result in an output register, so new
// items are taken while a result waits on a stalled receiver; once the queue
// is full, item_ready drops. The back end sequencer takes one item at a time
// from the queue and steps IDLE, ISSUE, EXEC, DONE for bounds, clear and
// fitness reports without improvement, with INIT2 after EXEC for element
// init, and IDLE, ISSUE, MA, MB, MC, MD, DONE for an element move. When an
// improvement copies a row, COPY walks the n elements of the row (n is
// dims_in_use capped at MAX_DIMS) before DONE. The inertia weight comes from
// a serial divider, waited on in DIV before MA, run only when the iteration
// number differs from the previous move or a register was written. Reset
// empties the queue and sequencer, restores register defaults and sets the
// global best to the largest 64-bit value (none); the swarm memories are not
// cleared and hold nothing meaningful until written.
`default_nettype none

module particle_swarm_update_engine_core import psue_pkg::*; #(
	parameter int unsigned MAX_PARTICLES = 64,
	parameter int unsigned MAX_DIMS = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready,
	// items
	input  wire logic               item_valid,
	output      logic               item_ready,
	input  wire logic [2:0]         mode,
	input  wire logic [5:0]         particle,
	input  wire logic [6:0]         dimension,
	input  wire logic signed [31:0] lower_value,
	input  wire logic signed [31:0] upper_value,
	input  wire logic [16:0]        rand_first,
	input  wire logic [16:0]        rand_second,
	input  wire logic [15:0]        iteration,
	input  wire logic signed [63:0] fitness,
	// results
	output      logic               result_valid,
	input  wire logic               result_ready,
	output      logic signed [31:0] position,
	output      logic signed [63:0] best_fitness,
	output      logic               personal_improved,
	output      logic               global_improved
);

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] reg_idx;
	logic       q_valid, q_pop;
	cmd_t       q_item;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inertia_start        <= RST_INERTIA_START;
			cfg_q.inertia_end          <= RST_INERTIA_END;
			cfg_q.cognitive_gain       <= RST_COGNITIVE_GAIN;
			cfg_q.social_gain          <= RST_SOCIAL_GAIN;
			cfg_q.iteration_limit      <= RST_ITERATION_LIMIT;
			cfg_q.speed_limit_fraction <= RST_SPEED_LIMIT;
			cfg_q.dims_in_use          <= RST_DIMS_IN_USE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INERTIA_START:   cfg_q.inertia_start        <= pwdata[16:0];
				REG_INERTIA_END:     cfg_q.inertia_end          <= pwdata[16:0];
				REG_COGNITIVE_GAIN:  cfg_q.cognitive_gain       <= pwdata[17:0];
				REG_SOCIAL_GAIN:     cfg_q.social_gain          <= pwdata[17:0];
				REG_ITERATION_LIMIT: cfg_q.iteration_limit      <= pwdata[15:0];
				REG_SPEED_LIMIT:     cfg_q.speed_limit_fraction <= pwdata[16:0];
				REG_DIMS_IN_USE:     cfg_q.dims_in_use          <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INERTIA_START:   prdata = 32'(cfg_q.inertia_start);
			REG_INERTIA_END:     prdata = 32'(cfg_q.inertia_end);
			REG_COGNITIVE_GAIN:  prdata = 32'(cfg_q.cognitive_gain);
			REG_SOCIAL_GAIN:     prdata = 32'(cfg_q.social_gain);
			REG_ITERATION_LIMIT: prdata = 32'(cfg_q.iteration_limit);
			REG_SPEED_LIMIT:     prdata = 32'(cfg_q.speed_limit_fraction);
			REG_DIMS_IN_USE:     prdata = 32'(cfg_q.dims_in_use);
			default:             prdata = 32'd0;
		endcase
	end

	psue_front #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.MAX_DIMS(MAX_DIMS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.particle(particle),
		.dimension(dimension),
		.lower_value(lower_value),
		.upper_value(upper_value),
		.rand_first(rand_first),
		.rand_second(rand_second),
		.iteration(iteration),
		.fitness(fitness),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	psue_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	psue_back #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.MAX_DIMS(MAX_DIMS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cfg_wr(cfg_wr),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.position(position),
		.best_fitness(best_fitness),
		.personal_improved(personal_improved),
		.global_improved(global_improved)
	);

	// a global improvement only comes with a personal one
	a_gimp_needs_pimp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && global_improved |-> personal_improved)
		else $error("global improvement without personal improvement");

	// a new global best is always a real score
	a_gimp_real_score: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && global_improved |-> best_fitness != FIT_NONE)
		else $error("global improvement left best_fitness at none");

	// fitness reports never carry a position
	a_report_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (personal_improved || global_improved) |-> position == 32'sd0)
		else $error("fitness report with nonzero position");

endmodule

`default_nettype wire
